FILE: rtl/core/kbw_pkg.sv
// shared types, constants and polynomial coefficients for the kaiser-bessel window block
`default_nettype none
package kbw_pkg;

	localparam int OUT_FRAC_BITS = 23;
	localparam int COEF_FRAC = 30;
	localparam int WV_W = 24;
	localparam int ACC_W = 31;
	localparam int POS_W = 32;
	localparam int QUO_W = POS_W + 1;
	localparam int DIV_STEPS = QUO_W;
	localparam int NUM_COEF = 12;
	localparam int HORNER_STEPS = NUM_COEF - 1;

	localparam logic [POS_W-1:0] W_RESET = 32'd65536;

	localparam int RND_SH = COEF_FRAC - OUT_FRAC_BITS;
	localparam logic [ACC_W:0] RND_HALF = (ACC_W + 1)'((64'd1 << RND_SH) >> 1);
	localparam logic [ACC_W:0] ONE_VAL = (ACC_W + 1)'(64'd1 << OUT_FRAC_BITS);

	localparam longint unsigned P30 = 64'd1073741824;
	localparam longint unsigned M6 = 64'd1000000;
	localparam longint unsigned T12 = 64'd1000000000000;
	localparam longint unsigned H12 = 64'd500000000000;

	// coefficient digits: integer part of value * 1e6 and the next six digits
	localparam longint unsigned KA [NUM_COEF] = '{
		64'd11479, 64'd113302, 64'd279562, 64'd306574, 64'd189110, 64'd74657,
		64'd20467, 64'd4122, 64'd635, 64'd77, 64'd7, 64'd0
	};
	localparam longint unsigned KB [NUM_COEF] = '{
		64'd934538, 64'd412440, 64'd497118, 64'd583548, 64'd616191, 64'd878794,
		64'd881364, 64'd650857, 64'd764579, 64'd465986, 64'd645586, 64'd623627
	};

	localparam logic [ACC_W-1:0] KCOEF [NUM_COEF] = '{
		ACC_W'(KA[0] * P30 / M6 + ((KA[0] * P30 % M6) * M6 + KB[0] * P30 + H12) / T12),
		ACC_W'(KA[1] * P30 / M6 + ((KA[1] * P30 % M6) * M6 + KB[1] * P30 + H12) / T12),
		ACC_W'(KA[2] * P30 / M6 + ((KA[2] * P30 % M6) * M6 + KB[2] * P30 + H12) / T12),
		ACC_W'(KA[3] * P30 / M6 + ((KA[3] * P30 % M6) * M6 + KB[3] * P30 + H12) / T12),
		ACC_W'(KA[4] * P30 / M6 + ((KA[4] * P30 % M6) * M6 + KB[4] * P30 + H12) / T12),
		ACC_W'(KA[5] * P30 / M6 + ((KA[5] * P30 % M6) * M6 + KB[5] * P30 + H12) / T12),
		ACC_W'(KA[6] * P30 / M6 + ((KA[6] * P30 % M6) * M6 + KB[6] * P30 + H12) / T12),
		ACC_W'(KA[7] * P30 / M6 + ((KA[7] * P30 % M6) * M6 + KB[7] * P30 + H12) / T12),
		ACC_W'(KA[8] * P30 / M6 + ((KA[8] * P30 % M6) * M6 + KB[8] * P30 + H12) / T12),
		ACC_W'(KA[9] * P30 / M6 + ((KA[9] * P30 % M6) * M6 + KB[9] * P30 + H12) / T12),
		ACC_W'(KA[10] * P30 / M6 + ((KA[10] * P30 % M6) * M6 + KB[10] * P30 + H12) / T12),
		ACC_W'(KA[11] * P30 / M6 + ((KA[11] * P30 % M6) * M6 + KB[11] * P30 + H12) / T12)
	};

	typedef struct packed {
		logic vld;
		logic hit;
	} tag_t;

endpackage
`default_nettype wire

FILE: rtl/core/kbw_div_cell.sv
// one restoring division cell: doubles the remainder and produces one quotient bit
`default_nettype none
module kbw_div_cell (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic [kbw_pkg::POS_W-1:0]   w,
	input  wire kbw_pkg::tag_t               prev_tag,
	input  wire logic [kbw_pkg::POS_W-1:0]   prev_rem,
	input  wire logic [kbw_pkg::QUO_W-1:0]   prev_quo,
	output kbw_pkg::tag_t                    tag,
	output logic      [kbw_pkg::POS_W-1:0]   rem,
	output logic      [kbw_pkg::QUO_W-1:0]   quo
);

	kbw_pkg::tag_t tag_s1;
	logic [kbw_pkg::POS_W-1:0] rem_s1;
	logic [kbw_pkg::QUO_W-1:0] quo_s1;
	logic [kbw_pkg::POS_W:0] dbl;
	logic [kbw_pkg::POS_W:0] diff;
	logic ge;

	always_comb begin
		dbl = {prev_rem, 1'b0};
		diff = dbl - {1'b0, w};
		ge = dbl >= {1'b0, w};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (en) begin
			tag_s1 <= prev_tag;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= ge ? diff[kbw_pkg::POS_W-1:0] : dbl[kbw_pkg::POS_W-1:0];
			quo_s1 <= {prev_quo[kbw_pkg::QUO_W-2:0], ge};
		end
	end

	assign tag = tag_s1;
	assign rem = rem_s1;
	assign quo = quo_s1;

endmodule
`default_nettype wire

FILE: rtl/core/kbw_horner_cell.sv
// one horner step: scale the accumulator by arg, then add this cell's coefficient
`default_nettype none
module kbw_horner_cell (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic [kbw_pkg::ACC_W-1:0]   coef,
	input  wire kbw_pkg::tag_t               prev_tag,
	input  wire logic [kbw_pkg::ACC_W-1:0]   prev_acc,
	input  wire logic [kbw_pkg::QUO_W-1:0]   prev_arg,
	output kbw_pkg::tag_t                    tag,
	output logic      [kbw_pkg::ACC_W-1:0]   acc,
	output logic      [kbw_pkg::QUO_W-1:0]   arg
);

	localparam int PROD_W = kbw_pkg::ACC_W + kbw_pkg::POS_W;

	kbw_pkg::tag_t tag_s1;
	kbw_pkg::tag_t tag_s2;
	logic [kbw_pkg::ACC_W-1:0] scaled_s1;
	logic [kbw_pkg::QUO_W-1:0] arg_s1;
	logic [kbw_pkg::ACC_W-1:0] acc_s2;
	logic [kbw_pkg::QUO_W-1:0] arg_s2;
	logic [PROD_W-1:0] prod;
	logic [kbw_pkg::ACC_W-1:0] scaled;
	logic [kbw_pkg::ACC_W:0] sum;

	always_comb begin
		prod = PROD_W'(prev_acc) * PROD_W'(prev_arg[kbw_pkg::POS_W-1:0]);
		// arg of exactly one leaves the accumulator as is
		scaled = prev_arg[kbw_pkg::POS_W] ? prev_acc : prod[PROD_W-1:kbw_pkg::POS_W];
		sum = {1'b0, coef} + {1'b0, scaled_s1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else if (en) begin
			tag_s1 <= prev_tag;
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			scaled_s1 <= scaled;
			arg_s1 <= prev_arg;
			acc_s2 <= sum[kbw_pkg::ACC_W-1:0];
			arg_s2 <= arg_s1;
		end
	end

	assign tag = tag_s2;
	assign acc = acc_s2;
	assign arg = arg_s2;

endmodule
`default_nettype wire

FILE: rtl/core/kaiser_bessel_window_alpha_2pi_top.sv
// Kaiser-Bessel window (alpha = 2 pi) evaluator: one sample position in, one window value out.
// Takes one word per clock while in_ready is high; a result passes an input register for the
// magnitude and window test, 33 cells of the restoring divider that forms 2|x|/W (one quotient
// bit per cell), a squaring register, a register forming 1 - c*c, the 11 horner cells, and
// rounding and saturation into the output register. That register is backed by a one-word
// skid buffer, so the input keeps flowing while one result waits; in_ready drops only once
// both hold a word. A width of 0 acts as 1 LSB. The user must write the window width
// register through the cfg port only while the block is empty; the block does not enforce it.
`default_nettype none
module kaiser_bessel_window_alpha_2pi_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [kbw_pkg::POS_W-1:0]         cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic signed [kbw_pkg::POS_W-1:0]  sample_position,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic      [kbw_pkg::WV_W-1:0]          window_value,
	output logic                                   inside_window
);

	localparam int POS_W = kbw_pkg::POS_W;
	localparam int QUO_W = kbw_pkg::QUO_W;
	localparam int ACC_W = kbw_pkg::ACC_W;
	localparam int NDIV = kbw_pkg::DIV_STEPS;
	localparam int NH = kbw_pkg::HORNER_STEPS;

	logic [POS_W-1:0] width_q;
	logic en;

	// front stage
	logic [POS_W-1:0] mag;
	logic in_win;
	kbw_pkg::tag_t tag_s1;
	logic [POS_W-1:0] mag_s1;

	// divider chain
	kbw_pkg::tag_t tag_d [NDIV+1];
	logic [POS_W-1:0] rem_d [NDIV+1];
	logic [QUO_W-1:0] quo_d [NDIV+1];

	// arg stages
	kbw_pkg::tag_t tag_s35;
	logic [2*POS_W-1:0] sq_s35;
	logic cfull_s35;
	kbw_pkg::tag_t tag_s36;
	logic [QUO_W-1:0] arg_s36;
	logic [POS_W:0] sq_ceil;

	// horner chain
	kbw_pkg::tag_t tag_h [NH+1];
	logic [ACC_W-1:0] acc_h [NH+1];
	logic [QUO_W-1:0] arg_h [NH+1];

	// rounding and output
	logic [ACC_W:0] rnd;
	logic [ACC_W:0] val;
	logic [kbw_pkg::WV_W-1:0] p_wv;
	logic p_vld;
	logic p_in;
	logic out_vld_q;
	logic [kbw_pkg::WV_W-1:0] out_wv_q;
	logic out_in_q;
	logic skid_vld_q;
	logic [kbw_pkg::WV_W-1:0] skid_wv_q;
	logic skid_in_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= kbw_pkg::W_RESET;
		end else if (cfg_valid && cfg_ready) begin
			width_q <= (cfg_data == '0) ? POS_W'(1) : cfg_data;
		end
	end

	assign en = !skid_vld_q;
	assign in_ready = en;

	always_comb begin
		mag = sample_position[POS_W-1] ? (~sample_position + POS_W'(1)) : sample_position;
		in_win = {mag, 1'b0} <= {1'b0, width_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (en) begin
			tag_s1.vld <= in_valid;
			tag_s1.hit <= in_win;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= in_win ? mag : '0;
		end
	end

	assign tag_d[0] = tag_s1;
	assign rem_d[0] = mag_s1;
	assign quo_d[0] = '0;

	for (genvar i = 0; i < NDIV; i++) begin : g_div
		kbw_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.w        (width_q),
			.prev_tag (tag_d[i]),
			.prev_rem (rem_d[i]),
			.prev_quo (quo_d[i]),
			.tag      (tag_d[i+1]),
			.rem      (rem_d[i+1]),
			.quo      (quo_d[i+1])
		);
	end

	// arg = 1 - c*c, floor taken as 1 - ceil(c*c)
	always_comb begin
		sq_ceil = {1'b0, sq_s35[2*POS_W-1:POS_W]} + (POS_W+1)'(|sq_s35[POS_W-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s35 <= '0;
			tag_s36 <= '0;
		end else if (en) begin
			tag_s35 <= tag_d[NDIV];
			tag_s36 <= tag_s35;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s35 <= (2*POS_W)'(quo_d[NDIV][POS_W-1:0]) * (2*POS_W)'(quo_d[NDIV][POS_W-1:0]);
			cfull_s35 <= quo_d[NDIV][POS_W];
			arg_s36 <= cfull_s35 ? '0 : ({1'b1, {POS_W{1'b0}}} - sq_ceil);
		end
	end

	assign tag_h[0] = tag_s36;
	assign acc_h[0] = kbw_pkg::KCOEF[kbw_pkg::NUM_COEF-1];
	assign arg_h[0] = arg_s36;

	for (genvar i = 0; i < NH; i++) begin : g_horner
		kbw_horner_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.coef     (kbw_pkg::KCOEF[NH-1-i]),
			.prev_tag (tag_h[i]),
			.prev_acc (acc_h[i]),
			.prev_arg (arg_h[i]),
			.tag      (tag_h[i+1]),
			.acc      (acc_h[i+1]),
			.arg      (arg_h[i+1])
		);
	end

	always_comb begin
		rnd = {1'b0, acc_h[NH]} + kbw_pkg::RND_HALF;
		val = rnd >> kbw_pkg::RND_SH;
		if (val > kbw_pkg::ONE_VAL) begin
			val = kbw_pkg::ONE_VAL;
		end
		p_vld = tag_h[NH].vld;
		p_in = tag_h[NH].hit;
		p_wv = p_in ? val[kbw_pkg::WV_W-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || out_ready) begin
			out_vld_q <= skid_vld_q || p_vld;
			skid_vld_q <= 1'b0;
		end else if (en && p_vld) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || out_ready) begin
			if (skid_vld_q) begin
				out_wv_q <= skid_wv_q;
				out_in_q <= skid_in_q;
			end else begin
				out_wv_q <= p_wv;
				out_in_q <= p_in;
			end
		end else if (en && p_vld) begin
			skid_wv_q <= p_wv;
			skid_in_q <= p_in;
		end
	end

	assign out_valid = out_vld_q;
	assign window_value = out_wv_q;
	assign inside_window = out_in_q;

	// the skid word only exists behind a held output word
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid word without output word");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && !out_ready))
		else $error("skid filled while output was free");

	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !out_in_q) |-> (out_wv_q == '0))
		else $error("nonzero value outside window");

	a_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> ({{(ACC_W + 1 - kbw_pkg::WV_W){1'b0}}, out_wv_q} <= kbw_pkg::ONE_VAL))
		else $error("window value above one");

endmodule
`default_nettype wire
